// File: design/rsp_pkg.sv
// Shared types, register codes and fixed-point constants for the ray-sphere pixel shader.
// No dependencies; every other design file imports this package.
package rsp_pkg;

    // Frame size limit and configuration port shape.
    localparam int MAX_SCREEN_SIDE = 4096;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CAM_X        = 3'd2,
        REG_CAM_Z        = 3'd3,
        REG_YAW_ANGLE    = 3'd4,
        REG_FOV_ANGLE    = 3'd5
    } t_cfg_reg;

    // Ray components before normalizing, and Q2.14 unit vectors after.
    typedef logic signed [31:0] t_raw;
    typedef logic signed [15:0] t_q14;

    // Pipeline depths of the arithmetic units.
    localparam int LAT_SIN   = 4;
    localparam int SQRT_BITS = 32;
    localparam int LAT_SQRT  = SQRT_BITS;
    localparam int DIV_BITS  = 15;
    localparam int LAT_DIV   = DIV_BITS + 1;
    localparam int NORM_DLY  = 2 + LAT_SQRT;
    localparam int LAT_NORM  = NORM_DLY + LAT_DIV;

    // Scene: camera-to-sphere vector in Q.8 and the sphere radius.
    localparam longint SPH_OFF_X = 200;
    localparam longint SPH_OFF_Z = 300;
    localparam longint CAM_H     = 20;
    localparam longint SPH_R     = 80;
    localparam longint L_X       = -SPH_OFF_X * 256;
    localparam longint L_Y       = CAM_H * 256;
    localparam longint L_Z       = SPH_OFF_Z * 256;
    localparam longint SPH_R_Q8  = SPH_R * 256;
    localparam longint SPH_C     = (L_X * L_X + L_Y * L_Y + L_Z * L_Z
                                    - SPH_R_Q8 * SPH_R_Q8) * 65536;

    // Light direction in Q2.14 and its dot product with the ray origin term.
    localparam longint LIGHT_X = 7077;
    localparam longint LIGHT_Y = 14154;
    localparam longint LIGHT_Z = 4246;
    localparam longint L_DOT   = (L_X * LIGHT_X + L_Y * LIGHT_Y + L_Z * LIGHT_Z) * 4194304;

    // Reciprocal of five for values below 2^18: x / 5 = (x * DIV5_MUL) >> 18.
    localparam logic [15:0] DIV5_MUL = 16'd52429;

    // Shading.
    localparam logic [7:0] GAIN_R    = 8'd200;
    localparam logic [7:0] GAIN_G    = 8'd120;
    localparam logic [7:0] GAIN_B    = 8'd60;
    localparam logic [7:0] SHADE_OFS = 8'd30;

endpackage

// File: design/rsp_sin.sv
// Four-stage pipelined polynomial sine, angle in 1/131072 turn, result in Q14.
// Depends on rsp_pkg.
module rsp_sin import rsp_pkg::*; (
    input  logic        i_clk,
    input  logic [16:0] i_angle,
    output t_q14        o_sin
);

    logic [1:0]  r_quad1, r_quad2, r_quad3;
    logic [15:0] r_u1, r_u2, r_u3;
    logic [15:0] r_x2_1, r_x2_2;
    logic [14:0] r_t1;
    logic [15:0] r_t;
    t_q14        r_sin;
    logic [15:0] n_u;
    logic [31:0] n_uu, n_xc, n_xt, n_ut, n_ur;
    logic [15:0] n_s;

    // Fold the angle into the first quadrant.
    always_comb begin
        n_u  = i_angle[15] ? (16'd32768 - {1'b0, i_angle[14:0]}) : {1'b0, i_angle[14:0]};
        n_uu = 32'(n_u) * 32'(n_u);
        n_xc = 32'(r_x2_1) * 32'd2320;
        n_xt = 32'(r_x2_2) * 32'(r_t1);
        n_ut = 32'(r_u3) * 32'(r_t);
        n_ur = n_ut + 32'd32768;
        n_s  = n_ur[31:16];
    end

    // One multiplication per stage, Horner order.
    always_ff @(posedge i_clk) begin
        r_quad1 <= i_angle[16:15];
        r_u1    <= n_u;
        r_x2_1  <= n_uu[30:15];

        r_quad2 <= r_quad1;
        r_u2    <= r_u1;
        r_x2_2  <= r_x2_1;
        r_t1    <= 15'd21024 - 15'(n_xc[31:15]);

        r_quad3 <= r_quad2;
        r_u3    <= r_u2;
        r_t     <= 16'd51472 - n_xt[30:15];

        r_sin   <= r_quad3[1] ? -$signed(n_s) : $signed(n_s);
    end

    assign o_sin = r_sin;

endmodule

// File: design/rsp_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor of the root.
// Depends on rsp_pkg.
module rsp_isqrt import rsp_pkg::*; (
    input  logic                 i_clk,
    input  logic [63:0]          i_rad,
    output logic [SQRT_BITS-1:0] o_root
);

    logic [63:0]          r_rem  [0:SQRT_BITS-1];
    logic [SQRT_BITS-1:0] r_root [0:SQRT_BITS-1];

    // Each stage tries the next lower root bit against the remainder.
    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_step
        localparam int B = SQRT_BITS - 1 - k;
        logic [63:0]          rem_in;
        logic [SQRT_BITS-1:0] root_in;
        logic [65:0]          test;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign test = (66'(root_in) << (B + 1)) + (66'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (66'(rem_in) >= test) begin
                r_rem[k]  <= rem_in - test[63:0];
                r_root[k] <= root_in | (SQRT_BITS'(1) << B);
            end else begin
                r_rem[k]  <= rem_in;
                r_root[k] <= root_in;
            end
        end
    end

    assign o_root = r_root[SQRT_BITS-1];

endmodule

// File: design/rsp_div.sv
// Pipelined signed division num * 2^14 / den, truncated toward zero, for |num| <= den.
// Depends on rsp_pkg.
module rsp_div import rsp_pkg::*; (
    input  logic        i_clk,
    input  t_raw        i_num,
    input  logic [31:0] i_den,
    output t_q14        o_quo
);

    logic [46:0]         r_rem [0:DIV_BITS];
    logic [DIV_BITS-1:0] r_q   [0:DIV_BITS];
    logic [31:0]         r_den [0:DIV_BITS];
    logic                r_neg [0:DIV_BITS];
    logic [31:0]         n_mag;

    // Split off the sign and scale the magnitude to Q14.
    assign n_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {1'b0, n_mag, 14'd0};
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_num[31];
    end

    // Restoring division, one quotient bit per stage from the top.
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
        localparam int B = DIV_BITS - 1 - k;
        logic [46:0] test;

        assign test = 47'(r_den[k]) << B;

        always_ff @(posedge i_clk) begin
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            if (r_rem[k] >= test) begin
                r_rem[k+1] <= r_rem[k] - test;
                r_q[k+1]   <= r_q[k] | (DIV_BITS'(1) << B);
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_q[k+1]   <= r_q[k];
            end
        end
    end

    assign o_quo = r_neg[DIV_BITS] ? -$signed({1'b0, r_q[DIV_BITS]})
                                   : $signed({1'b0, r_q[DIV_BITS]});

endmodule

// File: design/rsp_norm.sv
// Vector normalizer: squares, sum, pipelined root and three pipelined dividers.
// Depends on rsp_pkg, rsp_isqrt and rsp_div.
module rsp_norm import rsp_pkg::*; (
    input  logic i_clk,
    input  t_raw i_x,
    input  t_raw i_y,
    input  t_raw i_z,
    output t_q14 o_x,
    output t_q14 o_y,
    output t_q14 o_z,
    output logic o_zero
);

    logic signed [63:0]   r_sq_x, r_sq_y, r_sq_z;
    logic [63:0]          r_sum;
    t_raw                 r_dl_x [0:NORM_DLY-1];
    t_raw                 r_dl_y [0:NORM_DLY-1];
    t_raw                 r_dl_z [0:NORM_DLY-1];
    logic                 r_zd   [0:LAT_DIV-1];
    logic [SQRT_BITS-1:0] root;

    // Squared length of the vector.
    always_ff @(posedge i_clk) begin
        r_sq_x <= i_x * i_x;
        r_sq_y <= i_y * i_y;
        r_sq_z <= i_z * i_z;
        r_sum  <= 64'(r_sq_x + r_sq_y + r_sq_z);
    end

    rsp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rad  (r_sum),
        .o_root (root)
    );

    // Hold the components until the length is known; a zero length is a miss.
    always_ff @(posedge i_clk) begin
        r_dl_x[0] <= i_x;
        r_dl_y[0] <= i_y;
        r_dl_z[0] <= i_z;
        for (int i = 1; i < NORM_DLY; i++) begin
            r_dl_x[i] <= r_dl_x[i-1];
            r_dl_y[i] <= r_dl_y[i-1];
            r_dl_z[i] <= r_dl_z[i-1];
        end
        r_zd[0] <= (root == '0);
        for (int i = 1; i < LAT_DIV; i++) begin
            r_zd[i] <= r_zd[i-1];
        end
    end

    rsp_div u_div_x (.i_clk(i_clk), .i_num(r_dl_x[NORM_DLY-1]), .i_den(root), .o_quo(o_x));
    rsp_div u_div_y (.i_clk(i_clk), .i_num(r_dl_y[NORM_DLY-1]), .i_den(root), .o_quo(o_y));
    rsp_div u_div_z (.i_clk(i_clk), .i_num(r_dl_z[NORM_DLY-1]), .i_den(root), .o_quo(o_z));

    assign o_zero = r_zd[LAT_DIV-1];

endmodule

// File: design/ray_sphere_pixel_shader.sv
// Top level of the ray-sphere pixel shader: configuration, ray setup, yaw turn,
// sphere test and Lambert shading. Depends on rsp_pkg, rsp_sin, rsp_isqrt and rsp_norm.
//
// Usage:
//   A pixel request (i_pixel_x, i_pixel_y) is taken at a rising edge with start high
//   and busy low. busy is always low: the pipeline takes one request every cycle.
//   Each request gives one result (o_red, o_green, o_blue, o_sphere_hit), shown for
//   one cycle with o_strobe high.
//   Results leave in request order; the receiver cannot stall and need not.
//   Throughput is one pixel per clock. The latency is set by the two normalizers
//   (a 32-stage square root and 16-stage dividers each) and the 32-stage root of
//   the sphere test.
//   Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_wdata while no
//   request is in flight. Sine and cosine of fov and yaw follow the registers
//   through a 4-stage unit. The camera position is accepted and has no effect.
//   Reset (i_rst_n low at a clock edge) clears the pipeline valid bits and loads
//   the default frame of 640 by 480, yaw 0 and a sixty-degree field of view.
module ray_sphere_pixel_shader import rsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [11:0]           i_pixel_x,
    input  logic [11:0]           i_pixel_y,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_strobe,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_sphere_hit
);

    localparam int LAT = LAT_SIN + LAT_NORM + 2 + LAT_NORM + 3 + LAT_SQRT + 5;

    // Shading of one channel, clamped to 255.
    function automatic logic [7:0] shade(input logic [15:0] diff, input logic [7:0] gain);
        logic [23:0] prod;
        logic [10:0] sum;
        prod = 24'(diff) * 24'(gain);
        sum  = 11'(prod[23:14]) + 11'(SHADE_OFS);
        return (sum > 11'd255) ? 8'd255 : sum[7:0];
    endfunction

    logic [12:0]          r_frame_width, r_frame_height;
    logic [15:0]          r_yaw;
    logic [14:0]          r_fov;
    logic [12:0]          n_w, n_h;
    t_q14                 sin_fov, cos_fov, sin_yaw, cos_yaw;
    logic                 r_vld [0:LAT];
    logic signed [14:0]   r_dx [0:LAT_SIN-1];
    logic signed [14:0]   r_dy [0:LAT_SIN-1];
    logic [12:0]          r_h  [0:LAT_SIN-1];
    t_raw                 r_raw_x, r_raw_y, r_raw_z;
    t_q14                 dir_x, dir_y, dir_z;
    logic                 dir_zero;
    t_raw                 r_p_cx, r_p_sz, r_p_sx, r_p_cz;
    t_q14                 r_dir_y;
    logic                 r_z1;
    logic signed [32:0]   n_rot_x, n_rot_z;
    t_raw                 r_rot_x, r_rot_y, r_rot_z;
    t_q14                 rd_x, rd_y, rd_z;
    logic                 rd_zero;
    logic signed [39:0]   n_bsum;
    t_raw                 n_ldot;
    logic signed [27:0]   r_b1, r_b2, r_b3;
    t_raw                 r_ld1, r_ld2, r_ld3;
    logic                 r_hz1, r_hz2;
    logic signed [55:0]   r_bb;
    logic signed [57:0]   n_hh;
    logic                 n_hit;
    logic                 r_hit3;
    logic [63:0]          r_rad;
    logic [SQRT_BITS-1:0] sq_root;
    logic signed [27:0]   r_bd [0:LAT_SQRT-1];
    t_raw                 r_ldd [0:LAT_SQRT-1];
    logic                 r_hd [0:LAT_SQRT-1];
    logic signed [32:0]   n_t;
    logic signed [27:0]   r_t;
    t_raw                 r_ldt;
    logic                 r_hit_t1, r_hit_t2, r_hit_t3, r_hit_t4;
    logic signed [59:0]   r_prod;
    logic signed [63:0]   r_dot;
    logic [17:0]          n_x;
    logic [33:0]          r_q5;
    logic [15:0]          n_diff;
    logic [7:0]           r_red, r_green, r_blue;
    logic                 r_sphere_hit;

    // The pipeline never holds off a request.
    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
            r_yaw          <= 16'd0;
            r_fov          <= 15'd10923;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[12:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[12:0];
                REG_CAM_X, REG_CAM_Z: ;
                REG_YAW_ANGLE:    r_yaw          <= i_cfg_wdata[15:0];
                REG_FOV_ANGLE:    r_fov          <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Frame size limited to the largest supported screen side.
    assign n_w = (r_frame_width > 13'(MAX_SCREEN_SIDE)) ? 13'(MAX_SCREEN_SIDE) : r_frame_width;
    assign n_h = (r_frame_height > 13'(MAX_SCREEN_SIDE)) ? 13'(MAX_SCREEN_SIDE)
                                                         : r_frame_height;

    // Trig of the half field of view and of the yaw.
    rsp_sin u_sin_fov (.i_clk(i_clk), .i_angle({2'b0, r_fov}), .o_sin(sin_fov));
    rsp_sin u_cos_fov (.i_clk(i_clk), .i_angle({2'b0, r_fov} + 17'd32768), .o_sin(cos_fov));
    rsp_sin u_sin_yaw (.i_clk(i_clk), .i_angle({r_yaw, 1'b0}), .o_sin(sin_yaw));
    rsp_sin u_cos_yaw (.i_clk(i_clk), .i_angle({r_yaw, 1'b0} + 17'd32768), .o_sin(cos_yaw));

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int i = 1; i <= LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Screen offsets of the pixel, held until the fov trig has settled.
    always_ff @(posedge i_clk) begin
        r_dx[0] <= $signed({2'b0, i_pixel_x, 1'b1}) - $signed({2'b0, n_w});
        r_dy[0] <= $signed({2'b0, n_h}) - $signed({2'b0, i_pixel_y, 1'b1});
        r_h[0]  <= n_h;
        for (int i = 1; i < LAT_SIN; i++) begin
            r_dx[i] <= r_dx[i-1];
            r_dy[i] <= r_dy[i-1];
            r_h[i]  <= r_h[i-1];
        end
    end

    // Camera-space ray scaled by height times the cosine.
    always_ff @(posedge i_clk) begin
        r_raw_x <= 32'(r_dx[LAT_SIN-1]) * 32'(sin_fov);
        r_raw_y <= 32'(r_dy[LAT_SIN-1]) * 32'(sin_fov);
        r_raw_z <= -(32'($signed({1'b0, r_h[LAT_SIN-1]})) * 32'(cos_fov));
    end

    rsp_norm u_norm_cam (
        .i_clk  (i_clk),
        .i_x    (r_raw_x),
        .i_y    (r_raw_y),
        .i_z    (r_raw_z),
        .o_x    (dir_x),
        .o_y    (dir_y),
        .o_z    (dir_z),
        .o_zero (dir_zero)
    );

    // Yaw turn about the vertical axis, products then rounding.
    assign n_rot_x = (33'(r_p_cx) - 33'(r_p_sz) + 33'sd8192) >>> 14;
    assign n_rot_z = (33'(r_p_sx) + 33'(r_p_cz) + 33'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        r_p_cx  <= 32'(cos_yaw) * 32'(dir_x);
        r_p_sz  <= 32'(sin_yaw) * 32'(dir_z);
        r_p_sx  <= 32'(sin_yaw) * 32'(dir_x);
        r_p_cz  <= 32'(cos_yaw) * 32'(dir_z);
        r_dir_y <= dir_y;
        r_z1    <= dir_zero;
        // A zero-length ray stays zero so that the second normalizer flags it.
        r_rot_x <= r_z1 ? '0 : 32'(n_rot_x);
        r_rot_y <= r_z1 ? '0 : 32'(r_dir_y);
        r_rot_z <= r_z1 ? '0 : 32'(n_rot_z);
    end

    rsp_norm u_norm_world (
        .i_clk  (i_clk),
        .i_x    (r_rot_x),
        .i_y    (r_rot_y),
        .i_z    (r_rot_z),
        .o_x    (rd_x),
        .o_y    (rd_y),
        .o_z    (rd_z),
        .o_zero (rd_zero)
    );

    // Sphere test: b from the projection on the ray, then the discriminant.
    assign n_bsum = 40'(L_X) * 40'(rd_x) + 40'(L_Y) * 40'(rd_y) + 40'(L_Z) * 40'(rd_z);
    assign n_ldot = 32'(LIGHT_X) * 32'(rd_x) + 32'(LIGHT_Y) * 32'(rd_y)
                  + 32'(LIGHT_Z) * 32'(rd_z);
    assign n_hh   = 58'(r_bb) - 58'(SPH_C);
    assign n_hit  = r_b2[27] && !n_hh[57] && !r_hz2;

    always_ff @(posedge i_clk) begin
        r_b1   <= 28'(n_bsum >>> 6);
        r_ld1  <= n_ldot;
        r_hz1  <= rd_zero;

        r_bb   <= r_b1 * r_b1;
        r_b2   <= r_b1;
        r_ld2  <= r_ld1;
        r_hz2  <= r_hz1;

        r_rad  <= n_hit ? 64'(n_hh) : '0;
        r_hit3 <= n_hit;
        r_b3   <= r_b2;
        r_ld3  <= r_ld2;
    end

    rsp_isqrt u_isqrt_hit (
        .i_clk  (i_clk),
        .i_rad  (r_rad),
        .o_root (sq_root)
    );

    // Carry b, the light term and the hit flag past the root.
    always_ff @(posedge i_clk) begin
        r_bd[0]  <= r_b3;
        r_ldd[0] <= r_ld3;
        r_hd[0]  <= r_hit3;
        for (int i = 1; i < LAT_SQRT; i++) begin
            r_bd[i]  <= r_bd[i-1];
            r_ldd[i] <= r_ldd[i-1];
            r_hd[i]  <= r_hd[i-1];
        end
    end

    // Hit distance, then the surface normal against the light.
    assign n_t    = -33'(r_bd[LAT_SQRT-1]) - $signed({1'b0, sq_root});
    assign n_x    = (r_dot > 64'sd0) ? r_dot[51:34] : '0;
    assign n_diff = r_q5[33:18];

    always_ff @(posedge i_clk) begin
        r_t      <= 28'(n_t);
        r_ldt    <= r_ldd[LAT_SQRT-1];
        r_hit_t1 <= r_hd[LAT_SQRT-1];

        r_prod   <= r_t * r_ldt;
        r_hit_t2 <= r_hit_t1;

        r_dot    <= 64'(L_DOT) + 64'(r_prod);
        r_hit_t3 <= r_hit_t2;

        r_q5     <= 34'(n_x) * 34'(DIV5_MUL);
        r_hit_t4 <= r_hit_t3;

        r_red        <= r_hit_t4 ? shade(n_diff, GAIN_R) : 8'd0;
        r_green      <= r_hit_t4 ? shade(n_diff, GAIN_G) : 8'd0;
        r_blue       <= r_hit_t4 ? shade(n_diff, GAIN_B) : 8'd0;
        r_sphere_hit <= r_hit_t4;
    end

    assign o_strobe     = r_vld[LAT];
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_sphere_hit = r_sphere_hit;

`ifndef SYNTHESIS
    // A miss is black.
    a_miss_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_sphere_hit) |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("miss result is not black");

    // A hit carries at least the shading offset.
    a_hit_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_sphere_hit) |-> (o_red >= SHADE_OFS && o_green >= SHADE_OFS
                                        && o_blue >= SHADE_OFS))
        else $error("hit result below shading offset");

    // Channel gains are ordered, and clamping keeps that order.
    a_gain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_sphere_hit) |-> (o_red >= o_green && o_green >= o_blue))
        else $error("channel order broken");
`endif

endmodule

// File: test/tb_top.sv
// Testbench for ray_sphere_pixel_shader: random and directed pixel requests under several
// frame, yaw and fov settings, checked against an in-bench shading predictor. Uses rsp_pkg.
module tb_top;
    import rsp_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [11:0]           i_pixel_x = '0;
    logic [11:0]           i_pixel_y = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_strobe;
    logic [7:0]            o_red, o_green, o_blue;
    logic                  o_sphere_hit;

    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
    } t_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       hit;
    } t_color;

    localparam int PIPE_LAT = 146;

    t_pixel pending_pixels[$];
    t_color expected_colors[$];
    int     errors = 0;
    int     gap_left = 0;
    logic   cfg_busy = 1'b0;

    // Shader settings mirrored in the bench.
    longint sh_w = 640, sh_h = 480, sh_yaw = 0, sh_fov = 10923;

    ray_sphere_pixel_shader u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint fdiv_floor(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b, x;
        r = 0; b = 64'sd1 <<< 62; x = v;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // Polynomial sine, 1/131072 turn in, Q14 out.
    function automatic longint poly_sin(longint a);
        longint q, u, x2, t, s;
        a = a & 64'h1FFFF;
        q = a >>> 15;
        u = a & 64'h7FFF;
        if (q[0]) u = 32768 - u;
        x2 = (u * u) >>> 15;
        t = 21024 - ((x2 * 2320) >>> 15);
        t = 51472 - ((x2 * t) >>> 15);
        s = (u * t + 32768) >>> 16;
        return q[1] ? -s : s;
    endfunction

    function automatic bit unit_vec(input longint d[3], output longint o[3]);
        longint n;
        n = int_sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
        if (n == 0) return 1'b0;
        for (int i = 0; i < 3; i++) o[i] = (d[i] * 16384) / n;
        return 1'b1;
    endfunction

    function automatic logic [7:0] shade(longint diff, longint gain);
        longint v;
        v = 30 + ((diff * gain) >>> 14);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_color shade_pixel(t_pixel p);
        t_color c;
        longint w, h, sh, ch, sy, cy, raw[3], dir[3], rot[3], rd[3];
        longint b, hh, t, dot, diff;
        c = '0;
        w = (sh_w > 4096) ? 4096 : sh_w;
        h = (sh_h > 4096) ? 4096 : sh_h;
        sh = poly_sin(sh_fov); ch = poly_sin(sh_fov + 32768);
        sy = poly_sin(sh_yaw * 2); cy = poly_sin(sh_yaw * 2 + 32768);
        raw[0] = (2 * longint'(p.px) + 1 - w) * sh;
        raw[1] = (h - 2 * longint'(p.py) - 1) * sh;
        raw[2] = -h * ch;
        if (!unit_vec(raw, dir)) return c;
        rot[0] = fdiv_floor(cy * dir[0] - sy * dir[2] + 8192, 14);
        rot[1] = dir[1];
        rot[2] = fdiv_floor(sy * dir[0] + cy * dir[2] + 8192, 14);
        if (!unit_vec(rot, rd)) return c;
        b = fdiv_floor(L_X * rd[0] + L_Y * rd[1] + L_Z * rd[2], 6);
        hh = b * b - SPH_C;
        if (b >= 0 || hh < 0) return c;
        t = -b - int_sqrt(hh);
        dot = (L_X * 4194304 + rd[0] * t) * LIGHT_X + (L_Y * 4194304 + rd[1] * t) * LIGHT_Y
            + (L_Z * 4194304 + rd[2] * t) * LIGHT_Z;
        diff = (dot > 0) ? dot / (64'sd80 * 64'sd1073741824) : 0;
        c.red = shade(diff, 200); c.green = shade(diff, 120); c.blue = shade(diff, 60);
        c.hit = 1'b1;
        return c;
    endfunction

    // Driver: pops pending pixels with random gaps, predicts at acceptance.
    always @(posedge i_clk) begin
        if (start && !busy) expected_colors.push_back(shade_pixel({i_pixel_x, i_pixel_y}));
        if (start && busy) begin
            // hold the current request
        end else if (gap_left > 0 || cfg_busy || pending_pixels.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
            t_pixel p;
            p = pending_pixels.pop_front();
            start <= 1'b1;
            i_pixel_x <= p.px;
            i_pixel_y <= p.py;
            if ($urandom_range(0, 3) == 0)
                gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 3);
        end
    end

    // Monitor: compares each strobed result with the oldest expected color.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_colors.size() == 0) begin
                $error("result with no pending request");
                errors++;
            end else begin
                t_color e;
                e = expected_colors.pop_front();
                if (o_red !== e.red) begin
                    $error("red exp %0d got %0d", e.red, o_red); errors++;
                end
                if (o_green !== e.green) begin
                    $error("green exp %0d got %0d", e.green, o_green); errors++;
                end
                if (o_blue !== e.blue) begin
                    $error("blue exp %0d got %0d", e.blue, o_blue); errors++;
                end
                if (o_sphere_hit !== e.hit) begin
                    $error("sphere_hit exp %0d got %0d", e.hit, o_sphere_hit); errors++;
                end
            end
        end
    end

    task automatic write_reg(t_cfg_reg idx, longint val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  sh_w = val & 64'h1FFF;
            REG_FRAME_HEIGHT: sh_h = val & 64'h1FFF;
            REG_YAW_ANGLE:    sh_yaw = val & 64'hFFFF;
            REG_FOV_ANGLE:    sh_fov = val & 64'h7FFF;
            default: ;
        endcase
    endtask

    // Waits until every queued pixel has been sent and answered. The check runs on the
    // falling edge so that the driver's updates at the rising edge are already visible.
    task automatic drain_all();
        while (pending_pixels.size() != 0 || start || expected_colors.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic queue_pixel(int x, int y);
        t_pixel p;
        p.px = 12'(x); p.py = 12'(y);
        pending_pixels.push_back(p);
    endtask

    // Mostly in-frame pixels of a small frame, some anywhere in the 12-bit range.
    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                queue_pixel($urandom_range(0, (sh_w > 0 && sh_w <= 4096) ? sh_w - 1 : 4095),
                            $urandom_range(0, (sh_h > 0 && sh_h <= 4096) ? sh_h - 1 : 4095));
        end
    endtask

    task automatic set_view(int w, int h, int yaw, int fov);
        cfg_busy = 1'b1;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CAM_X, $urandom_range(0, 24'hFFFFFF));
        write_reg(REG_CAM_Z, $urandom_range(0, 24'hFFFFFF));
        write_reg(REG_YAW_ANGLE, yaw);
        write_reg(REG_FOV_ANGLE, fov);
        // Let the sine units settle on the new angles.
        repeat (10) @(posedge i_clk);
        cfg_busy = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);

        // Directed: reset frame, corners, center, out-of-frame and full range.
        queue_pixel(0, 0); queue_pixel(639, 479); queue_pixel(320, 240);
        queue_pixel(0, 479); queue_pixel(639, 0); queue_pixel(4095, 4095);
        queue_pixel(4095, 0); queue_pixel(0, 4095); queue_pixel(2730, 1365);
        queue_pixel(1365, 2730);
        drain_all();
        // Zero height with zero fov: zero-length ray.
        set_view(0, 0, 0, 0);
        queue_pixel(0, 0); queue_pixel(4095, 4095);
        drain_all();
        // Zero width, oversized frame, widest fov.
        set_view(0, 8191, 65535, 32767);
        queue_pixel(5, 7); queue_pixel(4095, 4095); queue_pixel(0, 0);
        drain_all();
        set_view(5000, 1, 32768, 1);
        queue_pixel(2500, 0); queue_pixel(0, 0);
        drain_all();

        // Random phases: even phases set a yaw looking toward the sphere, odd phases any yaw.
        for (int ph = 0; ph < 8; ph++) begin
            int yaw;
            yaw = (ph % 2 == 0) ? 65536 - 6000 + $urandom_range(0, 4000)
                                : $urandom_range(0, 65535);
            set_view((ph == 3) ? 4096 : $urandom_range(1, 96),
                     (ph == 5) ? 4096 : $urandom_range(1, 96),
                     yaw, (ph == 6) ? 32767 : $urandom_range(1, 16000));
            queue_random(62);
            drain_all();
        end

        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (errors == 0 && expected_colors.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/rsp_pkg.sv
design/rsp_sin.sv
design/rsp_isqrt.sv
design/rsp_div.sv
design/rsp_norm.sv
design/ray_sphere_pixel_shader.sv
test/tb_top.sv
